// ===== rtl/dafp_pkg.sv =====
// Package for the dual converter frame pairer: drop codes, register indexes and the result item.
`timescale 1ns / 1ps

package dafp_pkg;

  // Which pending half, if any, an event threw away.
  typedef enum logic [2:0] {
    DROP_NONE          = 3'd0,
    DROP_ONE_TIMEOUT   = 3'd1,
    DROP_TWO_TIMEOUT   = 3'd2,
    DROP_ONE_OVERWRITE = 3'd3,
    DROP_TWO_OVERWRITE = 3'd4
  } drop_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RANK_ORDER   = 2'd0;
  localparam logic [1:0] CFG_PAIR_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_ADC_RUNNING  = 2'd2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd8400;

  // One result item as it sits in the output register or the skid register.
  typedef struct packed {
    logic        frame_out;
    logic [31:0] frame_seq;
    logic [11:0] m0_shunt_one;
    logic [11:0] m0_shunt_two;
    logic [11:0] m1_shunt_two;
    logic [11:0] m1_shunt_one;
    logic [11:0] bus_voltage;
    logic [11:0] switch_temp;
    logic        frame_valid;
    drop_t       drop_code;
    logic [31:0] pair_gap;
  } res_t;

endpackage

// ===== rtl/dual_adc_frame_pairer.sv =====
// Top level of the dual converter frame pairer: input register, pairing logic, output skid buffer.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Payload
//  ------    ---------  -------------------  ---------------------------------------------
//  in        sink       in_valid / in_stall  mode, time_now, sample_a .. sample_d
//  out       source     out_valid/out_stall  frame_out, frame_seq, six samples, frame_valid,
//                                            drop_code, pair_gap
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each item is held in the input register, passes through the pairing logic and goes to the
//  output register, or to the skid register while the output is stalled. One item is taken
//  every cycle while in_stall is low; the rate is set by the single pass through the pairing logic.
//  Reset (rst, synchronous) empties every stage, clears both pending halves and the sequence
//  count, and returns the registers to their reset values. cfg_ready is always high.
//  When the output is stalled the skid register takes one more result; only once that is full
//  does in_stall rise, and it depends on registered state alone.

module dual_adc_frame_pairer
  import dafp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] time_now,
  input  logic [11:0] sample_a,
  input  logic [11:0] sample_b,
  input  logic [11:0] sample_c,
  input  logic [11:0] sample_d,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_out,
  output logic [31:0] frame_seq,
  output logic [11:0] m0_shunt_one,
  output logic [11:0] m0_shunt_two,
  output logic [11:0] m1_shunt_two,
  output logic [11:0] m1_shunt_one,
  output logic [11:0] bus_voltage,
  output logic [11:0] switch_temp,
  output logic        frame_valid,
  output logic [2:0]  drop_code,
  output logic [31:0] pair_gap,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic        rank_order;
  logic [31:0] pair_timeout;
  logic        adc_running;

  // Input register.
  logic        s1_valid;
  logic        s1_mode;
  logic [31:0] s1_time;
  logic [11:0] s1_a;
  logic [11:0] s1_b;
  logic [11:0] s1_c;
  logic [11:0] s1_d;

  // Pairing state.
  logic        half_one_pending;
  logic        half_two_pending;
  logic [31:0] half_one_time;
  logic [31:0] half_two_time;
  logic [11:0] held_voltage;
  logic [11:0] held_temp;
  logic [11:0] held_ranks [4];
  logic [31:0] seq_count;

  // Output register and skid register.
  logic        main_valid;
  res_t        main_res;
  logic        skid_valid;
  res_t        skid_res;

  logic        in_accept;
  logic        fire;
  logic        main_free;

  // Pairing logic.
  logic        timeout_one;
  logic        timeout_two;
  logic        one_left;
  logic        two_left;
  logic        publish;
  logic [31:0] other_time;
  logic [31:0] gap_up;
  logic [31:0] gap_down;
  logic [11:0] rank0;
  logic [11:0] rank1;
  logic [11:0] rank2;
  logic [11:0] rank3;
  logic [11:0] volt_sel;
  logic [11:0] temp_sel;
  logic [31:0] seq_count_next;
  drop_t       drop;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid & skid_valid;
  assign in_accept = in_valid & ~in_stall;
  assign fire      = s1_valid & ~skid_valid;
  assign main_free = ~main_valid | ~out_stall;

  always_comb begin
    // A lone half that has waited longer than the timeout is thrown away first. Only one
    // half can be lone, so at most one of these is set.
    timeout_one = half_one_pending & ~half_two_pending &
                  ((s1_time - half_one_time) > pair_timeout);
    timeout_two = half_two_pending & ~half_one_pending &
                  ((s1_time - half_two_time) > pair_timeout);
    one_left    = half_one_pending & ~timeout_one;
    two_left    = half_two_pending & ~timeout_two;

    if (timeout_one) begin
      drop = DROP_ONE_TIMEOUT;
    end else if (timeout_two) begin
      drop = DROP_TWO_TIMEOUT;
    end else begin
      drop = DROP_NONE;
    end

    // The arriving half replaces its own side; the other side's stored values stand.
    if (s1_mode == 1'b0) begin
      if (one_left) begin
        drop = DROP_ONE_OVERWRITE;
      end
      publish    = two_left;
      other_time = half_two_time;
      volt_sel   = s1_a;
      temp_sel   = s1_b;
      rank0      = held_ranks[0];
      rank1      = held_ranks[1];
      rank2      = held_ranks[2];
      rank3      = held_ranks[3];
    end else begin
      if (two_left) begin
        drop = DROP_TWO_OVERWRITE;
      end
      publish    = one_left;
      other_time = half_one_time;
      volt_sel   = held_voltage;
      temp_sel   = held_temp;
      rank0      = s1_a;
      rank1      = s1_b;
      rank2      = s1_c;
      rank3      = s1_d;
    end

    // The gap is the plain unsigned distance between the two timestamps, with no wrap.
    gap_up   = s1_time - other_time;
    gap_down = other_time - s1_time;

    seq_count_next = publish ? seq_count + 32'd1 : seq_count;

    res           = '0;
    res.frame_seq = seq_count_next;
    res.drop_code = drop;
    if (publish) begin
      res.frame_out    = 1'b1;
      res.m0_shunt_one = rank_order ? rank1 : rank0;
      res.m0_shunt_two = rank_order ? rank0 : rank1;
      res.m1_shunt_two = rank2;
      res.m1_shunt_one = rank3;
      res.bus_voltage  = volt_sel;
      res.switch_temp  = temp_sel;
      res.frame_valid  = adc_running;
      res.pair_gap     = (s1_time < other_time) ? gap_down : gap_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_order   <= 1'b0;
      pair_timeout <= TIMEOUT_RESET;
      adc_running  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RANK_ORDER:   rank_order   <= cfg_data[0];
        CFG_PAIR_TIMEOUT: pair_timeout <= cfg_data;
        CFG_ADC_RUNNING:  adc_running  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: refilled whenever it empties or its item moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_mode <= mode;
      s1_time <= time_now;
      s1_a    <= sample_a;
      s1_b    <= sample_b;
      s1_c    <= sample_c;
      s1_d    <= sample_d;
    end
  end

  // Pairing state is updated only when the item in the input register moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_one_pending <= 1'b0;
      half_two_pending <= 1'b0;
      seq_count        <= '0;
    end else if (fire) begin
      seq_count <= seq_count_next;
      if (publish) begin
        half_one_pending <= 1'b0;
        half_two_pending <= 1'b0;
      end else if (s1_mode == 1'b0) begin
        half_one_pending <= 1'b1;
        half_two_pending <= two_left;
      end else begin
        half_one_pending <= one_left;
        half_two_pending <= 1'b1;
      end
    end
    if (fire) begin
      if (s1_mode == 1'b0) begin
        held_voltage  <= s1_a;
        held_temp     <= s1_b;
        half_one_time <= s1_time;
      end else begin
        held_ranks[0] <= s1_a;
        held_ranks[1] <= s1_b;
        held_ranks[2] <= s1_c;
        held_ranks[3] <= s1_d;
        half_two_time <= s1_time;
      end
    end
  end

  // Output register with a skid register behind it. A result goes to the output register when
  // that is free, otherwise it waits in the skid register, which drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid | fire;
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
    if (main_free) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (fire) begin
        main_res <= res;
      end
    end else if (fire) begin
      skid_res <= res;
    end
  end

  assign out_valid    = main_valid;
  assign frame_out    = main_res.frame_out;
  assign frame_seq    = main_res.frame_seq;
  assign m0_shunt_one = main_res.m0_shunt_one;
  assign m0_shunt_two = main_res.m0_shunt_two;
  assign m1_shunt_two = main_res.m1_shunt_two;
  assign m1_shunt_one = main_res.m1_shunt_one;
  assign bus_voltage  = main_res.bus_voltage;
  assign switch_temp  = main_res.switch_temp;
  assign frame_valid  = main_res.frame_valid;
  assign drop_code    = main_res.drop_code;
  assign pair_gap     = main_res.pair_gap;

endmodule

// ===== sim/dafp_tb_pkg.sv =====
// Scoreboard class for the frame pairer bench: predicts each result item and checks the block's.
`timescale 1ns / 1ps

package dafp_tb_pkg;
  import dafp_pkg::*;

  class pairing_scoreboard;
    // Own copy of the configuration registers.
    logic        order_swap;
    logic [31:0] timeout_cycles;
    logic        running;

    // Own copy of the pairing state.
    logic        one_held;
    logic        two_held;
    logic [31:0] one_stamp;
    logic [31:0] two_stamp;
    logic [11:0] held_volt;
    logic [11:0] held_temp;
    logic [11:0] held_rank [4];
    logic [31:0] frames_sent;

    res_t        expected_frames [$];
    int unsigned error_count;
    int unsigned event_count;
    int unsigned frame_count;
    int unsigned setting_count;
    int unsigned drop_tally [5];

    function new();
      order_swap     = 1'b0;
      timeout_cycles = TIMEOUT_RESET;
      running        = 1'b0;
      one_held       = 1'b0;
      two_held       = 1'b0;
      one_stamp      = '0;
      two_stamp      = '0;
      held_volt      = '0;
      held_temp      = '0;
      foreach (held_rank[i]) held_rank[i] = '0;
      frames_sent    = '0;
      error_count    = 0;
      event_count    = 0;
      frame_count    = 0;
      setting_count  = 0;
      foreach (drop_tally[i]) drop_tally[i] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        CFG_RANK_ORDER:   order_swap     = data[0];
        CFG_PAIR_TIMEOUT: timeout_cycles = data;
        CFG_ADC_RUNNING:  running        = data[0];
        default: ;
      endcase
    endfunction

    // Works out the result item caused by one accepted converter event.
    function void note_event(logic ev_mode, logic [31:0] now, logic [11:0] a, logic [11:0] b,
                             logic [11:0] c, logic [11:0] d);
      res_t        r;
      logic [31:0] elapsed;
      r = '0;
      r.drop_code = DROP_NONE;

      elapsed = now - one_stamp;
      if (one_held && !two_held && elapsed > timeout_cycles) begin
        one_held    = 1'b0;
        r.drop_code = DROP_ONE_TIMEOUT;
      end
      elapsed = now - two_stamp;
      if (two_held && !one_held && elapsed > timeout_cycles) begin
        two_held    = 1'b0;
        r.drop_code = DROP_TWO_TIMEOUT;
      end

      if (!ev_mode) begin
        if (one_held) r.drop_code = DROP_ONE_OVERWRITE;
        held_volt = a;
        held_temp = b;
        one_stamp = now;
        one_held  = 1'b1;
      end else begin
        if (two_held) r.drop_code = DROP_TWO_OVERWRITE;
        held_rank[0] = a;
        held_rank[1] = b;
        held_rank[2] = c;
        held_rank[3] = d;
        two_stamp    = now;
        two_held     = 1'b1;
      end

      if (one_held && two_held) begin
        frames_sent    = frames_sent + 32'd1;
        r.frame_out    = 1'b1;
        r.m0_shunt_one = order_swap ? held_rank[1] : held_rank[0];
        r.m0_shunt_two = order_swap ? held_rank[0] : held_rank[1];
        r.m1_shunt_two = held_rank[2];
        r.m1_shunt_one = held_rank[3];
        r.bus_voltage  = held_volt;
        r.switch_temp  = held_temp;
        r.frame_valid  = running;
        // Plain unsigned difference, deliberately not wrap-aware.
        r.pair_gap     = (one_stamp < two_stamp) ? two_stamp - one_stamp : one_stamp - two_stamp;
        one_held       = 1'b0;
        two_held       = 1'b0;
        one_stamp      = '0;
        two_stamp      = '0;
        frame_count++;
      end

      r.frame_seq = frames_sent;
      drop_tally[r.drop_code]++;
      event_count++;
      expected_frames.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_frame(res_t got);
      res_t want;
      if (expected_frames.size() == 0) begin
        $error("result item arrived with nothing expected");
        error_count++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_out",    want.frame_out,    got.frame_out);
      compare_field("frame_seq",    want.frame_seq,    got.frame_seq);
      compare_field("m0_shunt_one", want.m0_shunt_one, got.m0_shunt_one);
      compare_field("m0_shunt_two", want.m0_shunt_two, got.m0_shunt_two);
      compare_field("m1_shunt_two", want.m1_shunt_two, got.m1_shunt_two);
      compare_field("m1_shunt_one", want.m1_shunt_one, got.m1_shunt_one);
      compare_field("bus_voltage",  want.bus_voltage,  got.bus_voltage);
      compare_field("switch_temp",  want.switch_temp,  got.switch_temp);
      compare_field("frame_valid",  want.frame_valid,  got.frame_valid);
      compare_field("drop_code",    want.drop_code,    got.drop_code);
      compare_field("pair_gap",     want.pair_gap,     got.pair_gap);
    endfunction
  endclass

endpackage

// ===== sim/tb_dual_adc_frame_pairer.sv =====
// Self-checking bench for the dual converter frame pairer: directed and random converter events.
`timescale 1ns / 1ps

module tb_dual_adc_frame_pairer;
  import dafp_pkg::*;
  import dafp_tb_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // Two register stages inside the block: the input register and the output register.
  localparam int PIPE_DEPTH = 2;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [31:0] time_now = '0;
  logic [11:0] sample_a = '0;
  logic [11:0] sample_b = '0;
  logic [11:0] sample_c = '0;
  logic [11:0] sample_d = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_out;
  logic [31:0] frame_seq;
  logic [11:0] m0_shunt_one;
  logic [11:0] m0_shunt_two;
  logic [11:0] m1_shunt_two;
  logic [11:0] m1_shunt_one;
  logic [11:0] bus_voltage;
  logic [11:0] switch_temp;
  logic        frame_valid;
  logic [2:0]  drop_code;
  logic [31:0] pair_gap;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RANK_ORDER;
  logic [31:0] cfg_data = '0;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  // Running timestamp from which the random events draw their completion times.
  logic [31:0] stamp = '0;

  pairing_scoreboard board = new();
  res_t              seen;

  dual_adc_frame_pairer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .time_now     (time_now),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .sample_c     (sample_c),
    .sample_d     (sample_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_out    (frame_out),
    .frame_seq    (frame_seq),
    .m0_shunt_one (m0_shunt_one),
    .m0_shunt_two (m0_shunt_two),
    .m1_shunt_two (m1_shunt_two),
    .m1_shunt_one (m1_shunt_one),
    .bus_voltage  (bus_voltage),
    .switch_temp  (switch_temp),
    .frame_valid  (frame_valid),
    .drop_code    (drop_code),
    .pair_gap     (pair_gap),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // The result item as the block presents it, gathered into the package's struct.
  assign seen = {frame_out, frame_seq, m0_shunt_one, m0_shunt_two, m1_shunt_two, m1_shunt_one,
                 bus_voltage, switch_temp, frame_valid, drop_code, pair_gap};

  // Receiver. Everything read here right after the edge still holds its value from before
  // the edge, so the acceptance test sees exactly what the block saw. The stall for the next
  // cycle is then chosen afresh.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_frame(seen);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // Offers one converter event, with random idle cycles in front of it, and waits until the
  // block takes it. Valid is left high on return, so a following event goes out back to back
  // without valid being lowered and raised in the same time step.
  task automatic send_event(input logic ev_mode, input logic [31:0] ev_time,
                            input logic [11:0] a, input logic [11:0] b,
                            input logic [11:0] c, input logic [11:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= ev_mode;
    time_now <= ev_time;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    sample_d <= d;
    do @(posedge clk); while (in_stall);
    board.note_event(ev_mode, ev_time, a, b, c, d);
  endtask

  // Stops offering events and waits until every expected result item has come out, then lets
  // the pipeline settle so that the block is idle before any register is touched.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (board.expected_frames.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // One register write; valid is left high so that writes can follow one another directly.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
  endtask

  // Writes all three registers, and optionally the unused index, while the block is idle.
  // The single-bit registers get random upper bits, which the block must ignore.
  task automatic set_config(input logic swap, input logic [31:0] timeout, input logic run,
                            input bit touch_spare);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(CFG_RANK_ORDER, {noise[31:1], swap});
    write_reg(CFG_PAIR_TIMEOUT, timeout);
    write_reg(CFG_ADC_RUNNING, {noise[30:0], run});
    if (touch_spare) write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
    board.setting_count++;
  endtask

  // Random events. Most are well-formed pairs, one half from each converter in either order,
  // close enough in time to pair. The rest are lone events placed so that they overwrite a
  // pending half, sit right on the timeout boundary, step just past it, or jump anywhere in
  // the timestamp range.
  task automatic random_block(input int n_items);
    int          sent;
    int unsigned roll;
    logic        first;
    logic        lone_mode;
    logic [31:0] span;
    logic [31:0] t_first;
    logic [31:0] t_second;
    logic [31:0] t_lone;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        first    = 1'($urandom_range(0, 1));
        span     = (board.timeout_cycles < 32'd5000) ? board.timeout_cycles : 32'd5000;
        t_first  = stamp;
        t_second = stamp + $urandom_range(0, span);
        send_event(first, t_first, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        send_event(!first, t_second, 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));
        stamp = t_second + $urandom_range(1, 200);
        sent  = sent + 2;
      end else begin
        lone_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       t_lone = stamp;
          1:       t_lone = stamp + board.timeout_cycles;
          2:       t_lone = stamp + board.timeout_cycles + 32'd1;
          default: t_lone = $urandom();
        endcase
        send_event(lone_mode, t_lone, 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));
        stamp = t_lone;
        sent  = sent + 1;
      end
    end
  endtask

  initial begin
    logic [31:0] timeouts [6];
    int          blk;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed events under the reset settings: straight rank order, timeout 8400, not running.
    // A lone converter one half at timestamp zero; its unused ranks must be ignored.
    send_event(1'b0, 32'd0, 12'hFFF, 12'h000, 12'hABC, 12'h123);
    // Converter two completes it; the first frame goes out.
    send_event(1'b1, 32'd100, 12'h000, 12'hFFF, 12'hFFF, 12'h000);
    // Two converter two halves in a row: the second overwrites the first.
    send_event(1'b1, 32'd300, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_event(1'b1, 32'd400, 12'h5A5, 12'hA5A, 12'h0F0, 12'hF0F);
    // Exactly the timeout after the pending half: still pairs.
    send_event(1'b0, 32'd8800, 12'h001, 12'h800, 12'h000, 12'h000);
    // One timestamp unit past the timeout: the lone half one is dropped, half two waits alone.
    send_event(1'b0, 32'd10000, 12'h7FF, 12'h400, 12'h000, 12'h000);
    send_event(1'b1, 32'd18401, 12'h111, 12'h222, 12'h333, 12'h444);
    // Converter one arrives long after: the lone half two times out.
    send_event(1'b0, 32'd26802, 12'h0AA, 12'h055, 12'h000, 12'h000);
    // Same timestamp again from converter one: an overwrite.
    send_event(1'b0, 32'd26802, 12'h0BB, 12'h066, 12'h000, 12'h000);
    // Halves either side of the timestamp wrap; the gap is taken without wrap awareness.
    send_event(1'b0, 32'hFFFF_FFF0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_event(1'b1, 32'h0000_0010, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);

    // Swapped ranks, running, and a zero timeout.
    drain_block();
    set_config(1'b1, 32'd0, 1'b1, 1'b1);
    send_event(1'b1, 32'd5, 12'h101, 12'h202, 12'h303, 12'h404);
    // Same timestamp: zero elapsed is not past a zero timeout.
    send_event(1'b0, 32'd5, 12'h505, 12'h606, 12'h000, 12'h000);
    send_event(1'b0, 32'd7, 12'h707, 12'h808, 12'h000, 12'h000);
    send_event(1'b1, 32'd8, 12'h909, 12'hA0A, 12'hB0B, 12'hC0C);
    send_event(1'b0, 32'd9, 12'hD0D, 12'hE0E, 12'h000, 12'h000);

    // Largest timeout: nothing can ever time out; timestamps at the top of the range.
    drain_block();
    set_config(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_event(1'b1, 32'hFFFF_FFFF, 12'hFFF, 12'h000, 12'hFFF, 12'h000);
    send_event(1'b0, 32'hFFFF_FFFE, 12'h000, 12'hFFF, 12'h000, 12'hFFF);
    send_event(1'b0, 32'd1, 12'h123, 12'h456, 12'h000, 12'h000);
    send_event(1'b1, 32'hFFFF_FFFF, 12'h789, 12'hABC, 12'hDEF, 12'h012);

    // Random part in three idling phases, with the settings changed between blocks. The
    // drain before each change is also where the sender waits for every expected result.
    timeouts = '{32'd0, 32'hFFFF_FFFF, TIMEOUT_RESET, 32'd1, 32'd300, 32'd0};
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      drain_block();
      case (blk / 4)
        0: begin
          send_idle = 31;
          recv_idle = 63;
        end
        1: begin
          send_idle = 63;
          recv_idle = 31;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      timeouts[5] = $urandom_range(1, 20000);
      set_config(blk[0], timeouts[blk % 6], blk[1], blk == 5);
      stamp = $urandom();
      random_block(BLOCK_ITEMS);
    end

    drain_block();
    repeat (8) @(posedge clk);

    $display("Covered %0d converter events over %0d register settings, %0d frames published.",
             board.event_count, board.setting_count, board.frame_count);
    $display("Drops seen: %0d/%0d timed out (one/two), %0d/%0d overwritten (one/two).",
             board.drop_tally[DROP_ONE_TIMEOUT], board.drop_tally[DROP_TWO_TIMEOUT],
             board.drop_tally[DROP_ONE_OVERWRITE], board.drop_tally[DROP_TWO_OVERWRITE]);
    if (board.error_count == 0 && board.expected_frames.size() == 0) begin
      $display("dual_adc_frame_pairer: match");
    end else begin
      $display("dual_adc_frame_pairer: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("dual_adc_frame_pairer: mismatch");
    $finish;
  end

endmodule
